/* rtl/core/spn_pkg.sv */
// Shared types, constants and the S-box for the 16-bit SPN block cipher core.
// No dependencies; used by spn_round, the top level and the port checker.
package spn_pkg;

	localparam int NUM_ROUNDS     = 6;
	localparam int NUM_ROUND_KEYS = 6;
	localparam int NUM_KEY_REGS   = NUM_ROUND_KEYS + 1;
	localparam int BLOCK_W        = 16;
	localparam int NIB_W          = 4;
	localparam int NUM_NIBS       = BLOCK_W / NIB_W;
	localparam int APB_DATA_W     = 32;
	localparam int REG_IDX_W      = 3;
	localparam int APB_ADDR_W     = REG_IDX_W + 2;

	typedef logic [BLOCK_W-1:0] block_t;
	typedef logic [NIB_W-1:0]   nibble_t;

	// Register map, one 32-bit word per key
	typedef enum logic [REG_IDX_W-1:0] {
		REG_ROUND_KEY_0   = 3'd0,
		REG_ROUND_KEY_1   = 3'd1,
		REG_ROUND_KEY_2   = 3'd2,
		REG_ROUND_KEY_3   = 3'd3,
		REG_ROUND_KEY_4   = 3'd4,
		REG_ROUND_KEY_5   = 3'd5,
		REG_WHITENING_KEY = 3'd6
	} reg_idx_t;

	// Fixed 4-bit substitution
	function automatic nibble_t sbox(input nibble_t x);
		nibble_t y;
		unique case (x)
			4'h0: y = 4'h4;
			4'h1: y = 4'hB;
			4'h2: y = 4'h1;
			4'h3: y = 4'hF;
			4'h4: y = 4'h9;
			4'h5: y = 4'h2;
			4'h6: y = 4'hE;
			4'h7: y = 4'hC;
			4'h8: y = 4'h6;
			4'h9: y = 4'hA;
			4'hA: y = 4'h8;
			4'hB: y = 4'h7;
			4'hC: y = 4'h3;
			4'hD: y = 4'h5;
			4'hE: y = 4'h0;
			default: y = 4'hD;
		endcase
		return y;
	endfunction

endpackage

/* rtl/core/spn_round.sv */
// One cipher round: key mix, nibble substitution and 4x4 bit transposition.
// Depends on spn_pkg for the block type and the S-box.
module spn_round import spn_pkg::*; (
	input  block_t blk,
	input  block_t key,
	output block_t result
);

	block_t  mixed;
	block_t  subst;

	// Mix in the round key
	assign mixed = blk ^ key;

	// Substitute each nibble
	always_comb begin
		for (int n = 0; n < NUM_NIBS; n++) begin
			subst[n*NIB_W +: NIB_W] = sbox(mixed[n*NIB_W +: NIB_W]);
		end
	end

	// Transpose: result bit 4i+j takes bit i of substituted nibble j
	always_comb begin
		for (int i = 0; i < NIB_W; i++) begin
			for (int j = 0; j < NUM_NIBS; j++) begin
				result[i*NUM_NIBS + j] = subst[j*NIB_W + i];
			end
		end
	end

endmodule

/* rtl/core/spn_block_encrypt_16bit_core.sv */
// Top level of the 16-bit SPN block cipher core: key registers and round pipeline.
// Depends on spn_pkg and spn_round.
//
// Encrypts one 16-bit block per accepted beat. The datapath is a pipeline of
// six register stages, one cipher round each, with the whitening key folded
// into the last stage; a block's result leaves from the last stage, and a new
// block can be taken every cycle while plain_stall is low. Each stage advances
// on its own, so bubbles close up while the output is stalled, and plain_stall
// rises only when all six stages hold a block and cipher_stall is high. The
// seven 16-bit keys sit in the low half of 32-bit words at byte addresses
// 0x00 to 0x18 (round keys 0 to 5, then the whitening key); reset clears them
// to zero. Change keys only while no block is in flight.
module spn_block_encrypt_16bit_core import spn_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	// plaintext channel
	input  logic                  plain_valid,
	output logic                  plain_stall,
	input  logic [BLOCK_W-1:0]    plain_block,
	// ciphertext channel
	output logic                  cipher_valid,
	input  logic                  cipher_stall,
	output logic [BLOCK_W-1:0]    cipher_block
);

	block_t   key_q [NUM_KEY_REGS];
	reg_idx_t reg_idx;
	logic     reg_hit;
	logic     cfg_wr;

	block_t   blk_s  [NUM_ROUNDS];
	logic     vld_s  [NUM_ROUNDS];
	logic     rdy    [NUM_ROUNDS+1];

	// Decode the register index
	assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
	always_comb begin
		unique case (reg_idx)
			REG_ROUND_KEY_0, REG_ROUND_KEY_1, REG_ROUND_KEY_2,
			REG_ROUND_KEY_3, REG_ROUND_KEY_4, REG_ROUND_KEY_5,
			REG_WHITENING_KEY: reg_hit = 1'b1;
			default:           reg_hit = 1'b0;
		endcase
	end

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// Write the key registers; drop writes outside the map
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_KEY_REGS; k++) begin
				key_q[k] <= '0;
			end
		end else if (cfg_wr && reg_hit) begin
			key_q[reg_idx] <= pwdata[BLOCK_W-1:0];
		end
	end

	// Read back the addressed key
	assign prdata = reg_hit ? {{(APB_DATA_W-BLOCK_W){1'b0}}, key_q[reg_idx]} : '0;

	// Stage ready: a stage loads when empty or when its block moves on
	always_comb begin
		rdy[NUM_ROUNDS] = !cipher_stall;
		for (int r = NUM_ROUNDS - 1; r >= 0; r--) begin
			rdy[r] = !vld_s[r] || rdy[r+1];
		end
	end

	assign plain_stall = !rdy[0];

	// One round per stage
	for (genvar r = 0; r < NUM_ROUNDS; r++) begin : g_stage
		localparam int KeyIdx = (r < NUM_ROUND_KEYS) ? r : NUM_ROUND_KEYS - 1;
		block_t stage_in;
		block_t round_out;
		block_t stage_out;
		logic   prev_vld;

		if (r == 0) begin : g_first
			assign stage_in = plain_block;
			assign prev_vld = plain_valid;
		end else begin : g_next
			assign stage_in = blk_s[r-1];
			assign prev_vld = vld_s[r-1];
		end

		spn_round u_round (
			.blk    (stage_in),
			.key    (key_q[KeyIdx]),
			.result (round_out)
		);

		// Fold the whitening key into the last stage
		if (r == NUM_ROUNDS - 1) begin : g_white
			assign stage_out = round_out ^ key_q[NUM_KEY_REGS-1];
		end else begin : g_plain
			assign stage_out = round_out;
		end

		// Advance the valid bit
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[r] <= 1'b0;
			end else if (rdy[r]) begin
				vld_s[r] <= prev_vld;
			end
		end

		// Advance the block; hold it while stalled
		always_ff @(posedge clk) begin
			if (rdy[r] && prev_vld) begin
				blk_s[r] <= stage_out;
			end
		end
	end

	assign cipher_valid = vld_s[NUM_ROUNDS-1];
	assign cipher_block = blk_s[NUM_ROUNDS-1];

endmodule

/* rtl/core/spn_checker.sv */
// Port-level checker for the SPN cipher core, bound to the top level.
// Depends on spn_pkg for port widths.
module spn_checker import spn_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  psel,
	input logic                  penable,
	input logic                  pwrite,
	input logic [APB_ADDR_W-1:0] paddr,
	input logic [APB_DATA_W-1:0] pwdata,
	input logic [APB_DATA_W-1:0] prdata,
	input logic                  pready,
	input logic                  plain_valid,
	input logic                  plain_stall,
	input logic [BLOCK_W-1:0]    plain_block,
	input logic                  cipher_valid,
	input logic                  cipher_stall,
	input logic [BLOCK_W-1:0]    cipher_block
);

	// A stalled plaintext beat holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		plain_valid && plain_stall |=> plain_valid && $stable(plain_block))
		else $error("stalled plain beat changed");

	// A stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cipher_valid && cipher_stall |=> cipher_valid && $stable(cipher_block))
		else $error("stalled cipher beat changed");

	// Input backpressure only comes from a stalled, occupied output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		plain_stall |-> cipher_valid && cipher_stall)
		else $error("plain_stall without output backpressure");

	// An empty output stage means the pipeline can take a beat
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!cipher_valid |-> !plain_stall)
		else $error("plain_stall while output is empty");

	// A key read right after its write returns the written value
	a_key_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && !pwrite && $past(psel && penable && pwrite && pready)
		&& paddr == $past(paddr) && paddr[APB_ADDR_W-1:2] < NUM_KEY_REGS
		|-> prdata == {{(APB_DATA_W-BLOCK_W){1'b0}}, $past(pwdata[BLOCK_W-1:0])})
		else $error("key readback mismatch");

endmodule

bind spn_block_encrypt_16bit_core spn_checker u_spn_checker (.*);
